// ===== hdl/lcdnw_pkg.sv =====
// Shared types and constants for the character LCD nibble writer.
package lcdnw_pkg;

    // Bus phases of the sequencer.
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START    = 4'd1,
        PH_ADDR_LO  = 4'd2,
        PH_ADDR_HI  = 4'd3,
        PH_AACK_LO  = 4'd4,
        PH_AACK_HI  = 4'd5,
        PH_DATA_LO  = 4'd6,
        PH_DATA_HI  = 4'd7,
        PH_DACK_LO  = 4'd8,
        PH_DACK_HI  = 4'd9,
        PH_STOP_LO  = 4'd10,
        PH_STOP_HI  = 4'd11,
        PH_STOP_END = 4'd12,
        PH_SETTLE   = 4'd13
    } phase_t;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_FULL_BYTE  = 2'd1;
    localparam logic [1:0] OP_LOW_NIBBLE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_BACKLIGHT_ON   = 2'd1;
    localparam logic [1:0] CFG_SETTLE_TICKS   = 2'd2;

    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd39;
    localparam logic        BACKLIGHT_ON_RST   = 1'b1;
    localparam logic [15:0] SETTLE_TICKS_RST   = 16'd40;

    // Write steps: 0..3 for a full byte, 4..5 for a low nibble only.
    localparam logic [2:0] STEP_FULL_FIRST = 3'd0;
    localparam logic [2:0] STEP_FULL_LAST  = 3'd3;
    localparam logic [2:0] STEP_LOW_FIRST  = 3'd4;
    localparam logic [2:0] STEP_LOW_LAST   = 3'd5;

    typedef struct packed {
        logic [6:0]  device_address;
        logic        backlight_on;
        logic [15:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic ready_res;
        logic ack_seen;
        logic request_dropped;
    } result_t;

endpackage

// ===== hdl/lcdnw_in_if.sv =====
// Input channel: one bus tick with an optional send request.
interface lcdnw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] payload_byte;
    logic       register_select;
    logic       sda_sample;

    modport source (output valid, output operation, output payload_byte,
                    output register_select, output sda_sample, input ready);
    modport sink   (input valid, input operation, input payload_byte,
                    input register_select, input sda_sample, output ready);
endinterface

// ===== hdl/lcdnw_out_if.sv =====
// Output channel: bus levels and status for one tick.
interface lcdnw_out_if;
    logic valid;
    logic ready;
    logic scl_level;
    logic sda_level;
    logic ready_res;
    logic ack_seen;
    logic request_dropped;

    modport source (output valid, output scl_level, output sda_level,
                    output ready_res, output ack_seen, output request_dropped,
                    input ready);
    modport sink   (input valid, input scl_level, input sda_level,
                    input ready_res, input ack_seen, input request_dropped,
                    output ready);
endinterface

// ===== hdl/i2c_char_lcd_nibble_writer.sv =====
// The result of a tick is registered and presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; the result register frees its slot as it is
// taken, so input ready only drops while a result waits and the sink is stalled.
// Reset: bus idle with both lines released, ack cleared, registers at their
// reset values (address 39, backlight on, settle 40); no result pending.
module i2c_char_lcd_nibble_writer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [lcdnw_pkg::CFG_DATA_W-1:0]  cfg_data,
    lcdnw_in_if.sink                          req,
    lcdnw_out_if.source                       res
);
    import lcdnw_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t res_data_reg;
    logic    res_valid_reg;
    logic    fire;

    assign req.ready = !res_valid_reg || res.ready;
    assign fire      = req.valid && req.ready;

    lcdnw_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcdnw_sequencer u_sequencer
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .operation       (req.operation),
        .payload_byte    (req.payload_byte),
        .register_select (req.register_select),
        .sda_sample      (req.sda_sample),
        .cfg             (cfg),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_data_reg <= result;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.scl_level       = res_data_reg.scl_level;
    assign res.sda_level       = res_data_reg.sda_level;
    assign res.ready_res       = res_data_reg.ready_res;
    assign res.ack_seen        = res_data_reg.ack_seen;
    assign res.request_dropped = res_data_reg.request_dropped;

endmodule

// ===== hdl/lcdnw_cfg_regs.sv =====
// Configuration registers of the nibble writer.
module lcdnw_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [lcdnw_pkg::CFG_DATA_W-1:0]      cfg_data,
    output lcdnw_pkg::cfg_t                       cfg
);
    import lcdnw_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RST;
            cfg_reg.backlight_on   <= BACKLIGHT_ON_RST;
            cfg_reg.settle_ticks   <= SETTLE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[6:0];
                CFG_BACKLIGHT_ON:   cfg_reg.backlight_on   <= cfg_data[0];
                CFG_SETTLE_TICKS:   cfg_reg.settle_ticks   <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/lcdnw_sequencer.sv =====
// Bus phase sequencer: advances at most one phase per accepted tick.
module lcdnw_sequencer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [1:0]           operation,
    input  logic [7:0]           payload_byte,
    input  logic                 register_select,
    input  logic                 sda_sample,
    input  lcdnw_pkg::cfg_t      cfg,
    output lcdnw_pkg::result_t   result
);
    import lcdnw_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [2:0]  bit_reg,      bit_next;
    logic [7:0]  shift_reg,    shift_next;
    logic [7:0]  pending_reg,  pending_next;
    logic        select_reg,   select_next;
    logic [2:0]  step_reg,     step_next;
    logic [15:0] settle_reg,   settle_next;
    logic        ack_reg,      ack_next;

    logic        request;
    logic        dropped;
    logic [3:0]  nibble;
    logic [7:0]  expander_byte;
    logic        cur_bit;

    // Expander byte: D7..D4 = nibble, BL = bit 3, EN = bit 2, RS = bit 0.
    always_comb
    begin
        nibble = (step_reg <= 3'd1) ? pending_reg[7:4] : pending_reg[3:0];
        expander_byte = {nibble, cfg.backlight_on, ~step_reg[0], 1'b0, select_reg};
    end

    always_comb
    begin
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        pending_next = pending_reg;
        select_next  = select_reg;
        step_next    = step_reg;
        settle_next  = settle_reg;
        ack_next     = ack_reg;
        request      = (operation == OP_FULL_BYTE) || (operation == OP_LOW_NIBBLE);
        dropped      = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (request)
            begin
                pending_next = payload_byte;
                select_next  = register_select;
                step_next    = (operation == OP_FULL_BYTE) ? STEP_FULL_FIRST
                                                           : STEP_LOW_FIRST;
                phase_next   = PH_START;
            end
        end
        else
        begin
            dropped = request;
            case (phase_reg)
                PH_START:
                begin
                    shift_next = {cfg.device_address, 1'b0};
                    bit_next   = 3'd7;
                    phase_next = PH_ADDR_LO;
                end
                PH_ADDR_LO: phase_next = PH_ADDR_HI;
                PH_DATA_LO: phase_next = PH_DATA_HI;
                PH_ADDR_HI, PH_DATA_HI:
                begin
                    if (bit_reg == 3'd0)
                    begin
                        phase_next = (phase_reg == PH_ADDR_HI) ? PH_AACK_LO : PH_DACK_LO;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 3'd1;
                        phase_next = (phase_reg == PH_ADDR_HI) ? PH_ADDR_LO : PH_DATA_LO;
                    end
                end
                PH_AACK_LO: phase_next = PH_AACK_HI;
                PH_DACK_LO: phase_next = PH_DACK_HI;
                PH_AACK_HI:
                begin
                    ack_next   = ~sda_sample;
                    shift_next = expander_byte;
                    bit_next   = 3'd7;
                    phase_next = PH_DATA_LO;
                end
                PH_DACK_HI:
                begin
                    ack_next   = ~sda_sample;
                    phase_next = PH_STOP_LO;
                end
                PH_STOP_LO: phase_next = PH_STOP_HI;
                PH_STOP_HI: phase_next = PH_STOP_END;
                PH_STOP_END:
                begin
                    if (step_reg == STEP_FULL_LAST)
                    begin
                        step_next = STEP_FULL_FIRST;
                        if (cfg.settle_ticks != 16'd0)
                        begin
                            settle_next = cfg.settle_ticks;
                            phase_next  = PH_SETTLE;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (step_reg >= STEP_LOW_LAST)
                    begin
                        step_next  = STEP_FULL_FIRST;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        step_next  = step_reg + 3'd1;
                        phase_next = PH_START;
                    end
                end
                PH_SETTLE:
                begin
                    if (settle_reg <= 16'd1)
                    begin
                        settle_next = 16'd0;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        settle_next = settle_reg - 16'd1;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Line levels belong to the phase entered on this tick.
    always_comb
    begin
        cur_bit = shift_next[bit_next];
        result.ready_res       = (phase_next == PH_IDLE);
        result.ack_seen        = ack_next;
        result.request_dropped = dropped;
        case (phase_next)
            PH_START:               begin result.scl_level = 1'b1; result.sda_level = 1'b0;    end
            PH_ADDR_LO, PH_DATA_LO: begin result.scl_level = 1'b0; result.sda_level = cur_bit; end
            PH_ADDR_HI, PH_DATA_HI: begin result.scl_level = 1'b1; result.sda_level = cur_bit; end
            PH_AACK_LO, PH_DACK_LO: begin result.scl_level = 1'b0; result.sda_level = 1'b1;    end
            PH_STOP_LO:             begin result.scl_level = 1'b0; result.sda_level = 1'b0;    end
            PH_STOP_HI:             begin result.scl_level = 1'b1; result.sda_level = 1'b0;    end
            default:                begin result.scl_level = 1'b1; result.sda_level = 1'b1;    end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_reg     <= 3'd0;
            shift_reg   <= 8'd0;
            pending_reg <= 8'd0;
            select_reg  <= 1'b0;
            step_reg    <= STEP_FULL_FIRST;
            settle_reg  <= 16'd0;
            ack_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            pending_reg <= pending_next;
            select_reg  <= select_next;
            step_reg    <= step_next;
            settle_reg  <= settle_next;
            ack_reg     <= ack_next;
        end
    end

endmodule

// ===== bench/tb_i2c_char_lcd_nibble_writer.sv =====
// Self-checking testbench for the I2C character LCD nibble writer: per-tick bus level prediction.
`timescale 1ns / 1ps

module tb_i2c_char_lcd_nibble_writer;
    import lcdnw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] EXP_RS = 8'h01;
    localparam logic [7:0] EXP_EN = 8'h04;
    localparam logic [7:0] EXP_BL = 8'h08;

    // Ticks from an accepted request until the block is idle again.
    localparam int FULL_BUSY_TICKS   = 160;
    localparam int NIBBLE_BUSY_TICKS = 80;

    localparam int QUIET_LIMIT    = 2000;
    localparam int SINK_BURST_LEN = 400;
    localparam int MAX_REPORTS    = 40;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        logic       rs;
        logic       sda;
    } lcd_tick_t;

    typedef enum {SDA_LOW, SDA_RELEASED, SDA_RANDOM} sda_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lcdnw_in_if  req_ch ();
    lcdnw_out_if res_ch ();

    i2c_char_lcd_nibble_writer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    // Bus controller shadow state and register copy.
    phase_t      lcd_phase;
    logic [3:0]  lcd_bit_pos;
    logic [7:0]  lcd_shift;
    logic [7:0]  lcd_payload;
    logic        lcd_rs;
    logic [2:0]  lcd_step;
    logic [15:0] lcd_settle_left;
    logic        lcd_ack;
    cfg_t        lcd_cfg;

    lcd_tick_t pending_ticks_q[$];
    result_t   expected_levels_q[$];

    int issued_total;
    int accepted_total;
    int fail_count;
    int full_started;
    int nibble_started;
    int dropped_total;
    int acked_bytes;
    int nacked_bytes;
    int cfg_writes;
    int input_stalls;
    int quiet_cycles;
    int sender_idle_pct;
    int sink_stall_pct;

    logic stall_burst_on;
    int   burst_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] expander_byte();
        logic [7:0] v;
        v = {(lcd_step <= 3'd1) ? lcd_payload[7:4] : lcd_payload[3:0], 4'b0000};
        if (lcd_rs)
            v = v | EXP_RS;
        if (lcd_cfg.backlight_on)
            v = v | EXP_BL;
        // Even steps raise the enable strobe, odd steps drop it.
        if (!lcd_step[0])
            v = v | EXP_EN;
        return v;
    endfunction

    task automatic predict_bus_tick(input lcd_tick_t t);
        logic    is_req;
        result_t r;
        is_req = (t.op == OP_FULL_BYTE) || (t.op == OP_LOW_NIBBLE);
        r = '0;
        if (lcd_phase == PH_IDLE)
        begin
            if (is_req)
            begin
                lcd_payload = t.data;
                lcd_rs      = t.rs;
                lcd_step    = (t.op == OP_FULL_BYTE) ? STEP_FULL_FIRST : STEP_LOW_FIRST;
                lcd_phase   = PH_START;
                if (t.op == OP_FULL_BYTE)
                    full_started++;
                else
                    nibble_started++;
            end
        end
        else
        begin
            r.request_dropped = is_req;
            if (is_req)
                dropped_total++;
            case (lcd_phase)
                PH_START:
                begin
                    lcd_shift   = {lcd_cfg.device_address, 1'b0};
                    lcd_bit_pos = 4'd7;
                    lcd_phase   = PH_ADDR_LO;
                end
                PH_ADDR_LO: lcd_phase = PH_ADDR_HI;
                PH_DATA_LO: lcd_phase = PH_DATA_HI;
                PH_ADDR_HI, PH_DATA_HI:
                begin
                    if (lcd_bit_pos == 4'd0)
                        lcd_phase = (lcd_phase == PH_ADDR_HI) ? PH_AACK_LO : PH_DACK_LO;
                    else
                    begin
                        lcd_bit_pos = lcd_bit_pos - 4'd1;
                        lcd_phase = (lcd_phase == PH_ADDR_HI) ? PH_ADDR_LO : PH_DATA_LO;
                    end
                end
                PH_AACK_LO: lcd_phase = PH_AACK_HI;
                PH_DACK_LO: lcd_phase = PH_DACK_HI;
                PH_AACK_HI, PH_DACK_HI:
                begin
                    lcd_ack = ~t.sda;
                    if (lcd_ack)
                        acked_bytes++;
                    else
                        nacked_bytes++;
                    if (lcd_phase == PH_AACK_HI)
                    begin
                        lcd_shift   = expander_byte();
                        lcd_bit_pos = 4'd7;
                        lcd_phase   = PH_DATA_LO;
                    end
                    else
                        lcd_phase = PH_STOP_LO;
                end
                PH_STOP_LO: lcd_phase = PH_STOP_HI;
                PH_STOP_HI: lcd_phase = PH_STOP_END;
                PH_STOP_END:
                begin
                    if (lcd_step == STEP_FULL_LAST)
                    begin
                        lcd_step = STEP_FULL_FIRST;
                        if (lcd_cfg.settle_ticks != 16'd0)
                        begin
                            lcd_settle_left = lcd_cfg.settle_ticks;
                            lcd_phase = PH_SETTLE;
                        end
                        else
                            lcd_phase = PH_IDLE;
                    end
                    else if (lcd_step >= STEP_LOW_LAST)
                    begin
                        lcd_step  = STEP_FULL_FIRST;
                        lcd_phase = PH_IDLE;
                    end
                    else
                    begin
                        lcd_step  = lcd_step + 3'd1;
                        lcd_phase = PH_START;
                    end
                end
                PH_SETTLE:
                begin
                    if (lcd_settle_left <= 16'd1)
                    begin
                        lcd_settle_left = 16'd0;
                        lcd_phase = PH_IDLE;
                    end
                    else
                        lcd_settle_left = lcd_settle_left - 16'd1;
                end
                default: lcd_phase = PH_IDLE;
            endcase
        end

        case (lcd_phase)
            PH_START, PH_STOP_HI:   {r.scl_level, r.sda_level} = 2'b10;
            PH_ADDR_LO, PH_DATA_LO: {r.scl_level, r.sda_level} = {1'b0, lcd_shift[lcd_bit_pos[2:0]]};
            PH_ADDR_HI, PH_DATA_HI: {r.scl_level, r.sda_level} = {1'b1, lcd_shift[lcd_bit_pos[2:0]]};
            PH_AACK_LO, PH_DACK_LO: {r.scl_level, r.sda_level} = 2'b01;
            PH_STOP_LO:             {r.scl_level, r.sda_level} = 2'b00;
            default:                {r.scl_level, r.sda_level} = 2'b11;
        endcase
        r.ready_res = (lcd_phase == PH_IDLE);
        r.ack_seen  = lcd_ack;
        expected_levels_q.push_back(r);
    endtask

    function automatic void check_bit(input string field, input logic want, input logic seen);
        if (seen !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0b actual %0b", $time, field, want, seen);
        end
    endfunction

    // Driver: presents queued ticks and feeds accepted ones to the predictor.
    always @(posedge clk)
    begin : tick_driver
        lcd_tick_t nxt;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                nxt.op   = req_ch.operation;
                nxt.data = req_ch.payload_byte;
                nxt.rs   = req_ch.register_select;
                nxt.sda  = req_ch.sda_sample;
                predict_bus_tick(nxt);
                accepted_total++;
            end
            if (req_ch.valid && !req_ch.ready)
                input_stalls++;
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_ticks_q.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = pending_ticks_q.pop_front();
                    req_ch.valid           <= 1'b1;
                    req_ch.operation       <= nxt.op;
                    req_ch.payload_byte    <= nxt.data;
                    req_ch.register_select <= nxt.rs;
                    req_ch.sda_sample      <= nxt.sda;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only has to look at it.
    always @(posedge clk)
    begin
        if (!stall_burst_on)
            burst_cycles <= 0;
        else if (burst_cycles < SINK_BURST_LEN)
            burst_cycles <= burst_cycles + 1;
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin : level_monitor
        result_t want;
        logic    hold;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_levels_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with no expectation, expected none actual %b",
                                 $time, {res_ch.scl_level, res_ch.sda_level, res_ch.ready_res,
                                         res_ch.ack_seen, res_ch.request_dropped});
                end
                else
                begin
                    want = expected_levels_q.pop_front();
                    check_bit("scl_level", want.scl_level, res_ch.scl_level);
                    check_bit("sda_level", want.sda_level, res_ch.sda_level);
                    check_bit("ready_res", want.ready_res, res_ch.ready_res);
                    check_bit("ack_seen", want.ack_seen, res_ch.ack_seen);
                    check_bit("request_dropped", want.request_dropped, res_ch.request_dropped);
                end
            end
            hold = stall_burst_on && (burst_cycles < SINK_BURST_LEN);
            res_ch.ready <= !hold && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("i2c_char_lcd_nibble_writer verification failed");
                $finish;
            end
        end
    end

    task automatic queue_tick(input logic [1:0] op, input logic [7:0] data, input logic rs,
                              input logic sda);
        lcd_tick_t t;
        t.op   = op;
        t.data = data;
        t.rs   = rs;
        t.sda  = sda;
        pending_ticks_q.push_back(t);
        issued_total++;
    endtask

    task automatic queue_plain_ticks(input int count, input sda_mode_t mode);
        logic [1:0] op;
        logic       s;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(7) == 0) ? OP_UNUSED : OP_TICK;
            case (mode)
                SDA_LOW:      s = 1'b0;
                SDA_RELEASED: s = 1'b1;
                default:      s = 1'($urandom_range(1));
            endcase
            queue_tick(op, 8'($urandom_range(255)), 1'($urandom_range(1)), s);
        end
    endtask

    task automatic queue_request(input logic [1:0] op, input logic [7:0] data, input logic rs);
        queue_tick(op, data, rs, 1'($urandom_range(1)));
    endtask

    // Well-formed requests, each on an idle tick, with stray requests mixed into the busy time.
    task automatic random_transfers(input int count);
        logic [1:0] op;
        int         busy;
        repeat (count)
        begin
            op = ($urandom_range(2) == 0) ? OP_LOW_NIBBLE : OP_FULL_BYTE;
            queue_request(op, 8'($urandom_range(255)), 1'($urandom_range(1)));
            busy = (op == OP_FULL_BYTE) ? FULL_BUSY_TICKS + lcd_cfg.settle_ticks
                                        : NIBBLE_BUSY_TICKS;
            for (int i = 0; i < busy; i++)
            begin
                if ($urandom_range(24) == 0)
                    queue_tick($urandom_range(1) ? OP_FULL_BYTE : OP_LOW_NIBBLE,
                               8'($urandom_range(255)), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
                else
                    queue_plain_ticks(1, SDA_RANDOM);
            end
            queue_plain_ticks($urandom_range(3), SDA_RANDOM);
        end
    endtask

    task automatic wait_all_done();
        while (accepted_total != issued_total || expected_levels_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] reg_index, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (reg_index)
            CFG_DEVICE_ADDRESS: lcd_cfg.device_address = value[6:0];
            CFG_BACKLIGHT_ON:   lcd_cfg.backlight_on   = value[0];
            CFG_SETTLE_TICKS:   lcd_cfg.settle_ticks   = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic random_phase(input int sender_pct, input int sink_pct);
        wait_all_done();
        write_reg(CFG_DEVICE_ADDRESS, 16'($urandom_range(127)));
        write_reg(CFG_BACKLIGHT_ON, 16'($urandom_range(1)));
        write_reg(CFG_SETTLE_TICKS, 16'($urandom_range(12)));
        sender_idle_pct = sender_pct;
        sink_stall_pct  = sink_pct;
        random_transfers(1);
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_DEVICE_ADDRESS;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.operation       = OP_TICK;
        req_ch.payload_byte    = 8'h00;
        req_ch.register_select = 1'b0;
        req_ch.sda_sample      = 1'b1;
        res_ch.ready           = 1'b0;
        stall_burst_on         = 1'b0;
        sender_idle_pct        = 0;
        sink_stall_pct         = 0;
        quiet_cycles           = 0;

        lcd_phase       = PH_IDLE;
        lcd_bit_pos     = 4'd0;
        lcd_shift       = 8'h00;
        lcd_payload     = 8'h00;
        lcd_rs          = 1'b0;
        lcd_step        = STEP_FULL_FIRST;
        lcd_settle_left = 16'd0;
        lcd_ack         = 1'b0;
        lcd_cfg.device_address = DEVICE_ADDRESS_RST;
        lcd_cfg.backlight_on   = BACKLIGHT_ON_RST;
        lcd_cfg.settle_ticks   = SETTLE_TICKS_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values, all acknowledged, then all refused, with two requests dropped while busy.
        queue_request(OP_FULL_BYTE, 8'h00, 1'b0);
        queue_plain_ticks(FULL_BUSY_TICKS + SETTLE_TICKS_RST, SDA_LOW);
        queue_request(OP_FULL_BYTE, 8'hFF, 1'b1);
        queue_plain_ticks(30, SDA_RELEASED);
        queue_request(OP_FULL_BYTE, 8'h12, 1'b1);
        queue_plain_ticks(30, SDA_RELEASED);
        queue_request(OP_LOW_NIBBLE, 8'h34, 1'b0);
        queue_plain_ticks(FULL_BUSY_TICKS + SETTLE_TICKS_RST - 62, SDA_RELEASED);
        // Nibble-only ignores the upper half; the second request lands on the first idle tick.
        queue_request(OP_LOW_NIBBLE, 8'h5A, 1'b1);
        queue_plain_ticks(NIBBLE_BUSY_TICKS, SDA_RANDOM);
        queue_request(OP_LOW_NIBBLE, 8'hA5, 1'b0);
        queue_plain_ticks(NIBBLE_BUSY_TICKS, SDA_RANDOM);
        wait_all_done();

        write_reg(CFG_DEVICE_ADDRESS, 16'd0);
        write_reg(CFG_BACKLIGHT_ON, 16'd0);
        write_reg(CFG_SETTLE_TICKS, 16'd0);
        queue_request(OP_FULL_BYTE, 8'h3C, 1'b0);
        queue_plain_ticks(FULL_BUSY_TICKS, SDA_RANDOM);
        queue_request(OP_FULL_BYTE, 8'hC3, 1'b1);
        queue_plain_ticks(FULL_BUSY_TICKS, SDA_RANDOM);
        wait_all_done();

        write_reg(CFG_DEVICE_ADDRESS, 16'd127);
        write_reg(CFG_BACKLIGHT_ON, 16'd1);
        write_reg(CFG_SETTLE_TICKS, 16'd1);
        queue_request(OP_FULL_BYTE, 8'h96, 1'b1);
        queue_plain_ticks(FULL_BUSY_TICKS + 1, SDA_RANDOM);

        // Registers changed while a byte is on the bus take effect where they are next read.
        queue_request(OP_FULL_BYTE, 8'h69, 1'b0);
        queue_plain_ticks(10, SDA_RANDOM);
        wait_all_done();
        write_reg(CFG_DEVICE_ADDRESS, 16'd39);
        queue_plain_ticks(40, SDA_RANDOM);
        wait_all_done();
        write_reg(CFG_BACKLIGHT_ON, 16'd0);
        queue_plain_ticks(60, SDA_RANDOM);
        wait_all_done();
        write_reg(CFG_SETTLE_TICKS, 16'd6);
        queue_plain_ticks(FULL_BUSY_TICKS + 6 - 110, SDA_RANDOM);
        wait_all_done();

        random_phase(0, 0);
        random_phase(67, 0);
        random_phase(0, 67);
        random_phase(34, 34);

        // Receiver holds off while the sender keeps offering, so the input side backs up.
        wait_all_done();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        @(posedge clk);
        stall_burst_on <= 1'b1;
        random_transfers(1);
        wait_all_done();
        stall_burst_on <= 1'b0;

        wait_all_done();
        repeat (4) @(posedge clk);
        if (expected_levels_q.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_levels_q.size());
        end
        $display("Run covered %0d ticks: %0d full-byte and %0d nibble requests, %0d dropped.",
                 accepted_total, full_started, nibble_started, dropped_total);
        $display("Bytes acked %0d, refused %0d; %0d register writes; %0d input stall cycles.",
                 acked_bytes, nacked_bytes, cfg_writes, input_stalls);
        if (fail_count == 0)
            $display("i2c_char_lcd_nibble_writer verification clean");
        else
            $display("i2c_char_lcd_nibble_writer verification failed");
        $finish;
    end

endmodule
